[hw/rtl/crcfr_pkg.sv]
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, constants and the CRC-32 byte update for the frame receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

	// Frame layout
	localparam int HEADER_BYTES = 44;
	localparam int TARGET_BYTES = 32;
	localparam int TAG_BYTES    = 32;

	// Widths
	localparam int POS_W   = 21;
	localparam int LEN_W   = 21;
	localparam int FLAGS_W = 16;
	localparam int MAGIC_W = 16;
	localparam int CFG_W   = 21;
	localparam int CFG_IDX_W = 2;

	// Header byte positions
	localparam logic [POS_W-1:0] POS_MAGIC_FIRST  = POS_W'(0);
	localparam logic [POS_W-1:0] POS_MAGIC_LAST   = POS_W'(1);
	localparam logic [POS_W-1:0] POS_FLAGS_FIRST  = POS_W'(2);
	localparam logic [POS_W-1:0] POS_FLAGS_LAST   = POS_W'(3);
	localparam logic [POS_W-1:0] POS_LEN_LAST     = POS_W'(7);
	localparam logic [POS_W-1:0] POS_TARGET_FIRST = POS_W'(8);
	localparam logic [POS_W-1:0] POS_TARGET_LAST  = POS_W'(8 + TARGET_BYTES - 1);
	localparam logic [POS_W-1:0] POS_CRC_FIRST    = POS_W'(HEADER_BYTES - 4);
	localparam logic [POS_W-1:0] POS_HDR_LAST     = POS_W'(HEADER_BYTES - 1);

	// CRC-32, reflected
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

	// Byte kinds
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_TARGET  = 2'd1;
	localparam logic [1:0] KIND_PAYLOAD = 2'd2;
	localparam logic [1:0] KIND_TAG     = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
	localparam logic [1:0] ST_LEN_OVER  = 2'd2;
	localparam logic [1:0] ST_CRC_BAD   = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAGIC       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAC_MASK    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COMP_MASK   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd3;

	localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = LEN_W'(1048576);

	// Queue between parser and output side
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	typedef struct packed {
		logic [MAGIC_W-1:0] magic;
		logic [FLAGS_W-1:0] mac_mask;
		logic [FLAGS_W-1:0] comp_mask;
		logic [LEN_W-1:0]   max_payload;
	} cfg_t;

	// One parsed item, before flag decode and field gating
	typedef struct packed {
		logic [7:0]         data;
		logic [1:0]         kind;
		logic [FLAGS_W-1:0] flags;
		logic [LEN_W-1:0]   length;
		logic               flags_ok;
		logic               len_ok;
		logic               done;
		logic [1:0]         status;
	} rec_t;

	function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
		end
		return r;
	endfunction

endpackage

[hw/rtl/crcfr_front.sv]
// ----------------------------------------------------------------------------
// crcfr_front
// Header parser, CRC engine and frame sequencer; one byte per cycle while fire is high.
// ----------------------------------------------------------------------------
module crcfr_front import crcfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output rec_t       rec
);

	typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_TAG} phase_t;

	phase_t             phase_q, phase_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [POS_W:0]     pos_inc;
	logic [7:0]         magic_q, magic_d;
	logic [FLAGS_W-1:0] flags_q, flags_d;
	logic [31:0]        len_q, len_d;
	logic [31:0]        exp_q, exp_d;
	logic [31:0]        crc_q, crc_d;
	logic [31:0]        crc_chk, exp_chk;
	logic               finish;
	logic [1:0]         kind;
	logic               done;
	logic [1:0]         status;
	logic               flags_ok, len_ok;

	always_comb begin
		phase_d  = phase_q;
		pos_inc  = {1'b0, pos_q} + 1'b1;
		pos_d    = pos_q;
		magic_d  = magic_q;
		flags_d  = flags_q;
		len_d    = len_q;
		exp_d    = exp_q;
		crc_d    = crc_q;
		crc_chk  = crc_q;
		exp_chk  = exp_q;
		finish   = 1'b0;
		kind     = KIND_HEADER;
		done     = 1'b0;
		status   = ST_OK;
		flags_ok = 1'b1;
		len_ok   = 1'b1;

		case (phase_q)
			PH_PAYLOAD: begin
				kind    = KIND_PAYLOAD;
				crc_d   = crc32_byte(crc_q, rx_byte);
				crc_chk = crc_d;
				if (32'(pos_inc) >= len_q) begin
					finish = 1'b1;
				end else begin
					pos_d = pos_inc[POS_W-1:0];
				end
			end
			PH_TAG: begin
				kind = KIND_TAG;
				if (pos_inc >= (POS_W+1)'(TAG_BYTES)) begin
					done    = 1'b1;
					phase_d = PH_HEADER;
					pos_d   = '0;
				end else begin
					pos_d = pos_inc[POS_W-1:0];
				end
			end
			default: begin
				// header; the unused phase code lands here too
				phase_d  = PH_HEADER;
				flags_ok = (pos_q >= POS_FLAGS_LAST);
				len_ok   = (pos_q >= POS_LEN_LAST);
				if (pos_q >= POS_TARGET_FIRST && pos_q <= POS_TARGET_LAST) begin
					kind = KIND_TARGET;
				end
				pos_d = pos_inc[POS_W-1:0];
				if (pos_q == POS_MAGIC_FIRST) begin
					magic_d = rx_byte;
					crc_d   = CRC_ONES;
				end else if (pos_q == POS_MAGIC_LAST) begin
					if ({magic_q, rx_byte} != cfg.magic) begin
						done   = 1'b1;
						status = ST_BAD_MAGIC;
						pos_d  = '0;
					end
				end else if (pos_q <= POS_FLAGS_LAST) begin
					flags_d = {flags_q[7:0], rx_byte};
				end else if (pos_q <= POS_LEN_LAST) begin
					len_d = {len_q[23:0], rx_byte};
					if (pos_q == POS_LEN_LAST && len_d > 32'(cfg.max_payload)) begin
						done   = 1'b1;
						status = ST_LEN_OVER;
						len_ok = 1'b0;
						pos_d  = '0;
					end
				end else if (pos_q >= POS_CRC_FIRST) begin
					exp_d   = {exp_q[23:0], rx_byte};
					exp_chk = exp_d;
					if (pos_q >= POS_HDR_LAST) begin
						pos_d = '0;
						if (len_q == '0) begin
							finish = 1'b1;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
			end
		endcase

		// end of payload: CRC check, then tag or end of frame
		if (finish) begin
			pos_d = '0;
			if ((crc_chk ^ CRC_ONES) != exp_chk) begin
				done    = 1'b1;
				status  = ST_CRC_BAD;
				phase_d = PH_HEADER;
			end else if ((flags_d & cfg.mac_mask) != '0) begin
				phase_d = PH_TAG;
			end else begin
				done    = 1'b1;
				phase_d = PH_HEADER;
			end
		end
	end

	assign rec.data     = rx_byte;
	assign rec.kind     = kind;
	assign rec.flags    = flags_d;
	assign rec.length   = len_d[LEN_W-1:0];
	assign rec.flags_ok = flags_ok;
	assign rec.len_ok   = len_ok;
	assign rec.done     = done;
	assign rec.status   = status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			magic_q <= '0;
			flags_q <= '0;
			len_q   <= '0;
			exp_q   <= '0;
			crc_q   <= CRC_ONES;
		end else if (fire) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			magic_q <= magic_d;
			flags_q <= flags_d;
			len_q   <= len_d;
			exp_q   <= exp_d;
			crc_q   <= crc_d;
		end
	end

endmodule

[hw/rtl/crcfr_fifo.sv]
// ----------------------------------------------------------------------------
// crcfr_fifo
// Short register queue of parsed items between parser and output side.
// ----------------------------------------------------------------------------
module crcfr_fifo import crcfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  rec_t din,
	input  logic rd_en,
	output logic full,
	output logic empty,
	output rec_t dout
);

	rec_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_PTR_W:0]   count_q;
	logic               do_wr, do_rd;

	assign full  = (count_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en & ~full;
	assign do_rd = rd_en & ~empty;
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/crcfr_back.sv]
// ----------------------------------------------------------------------------
// crcfr_back
// Output side: gates header fields not yet complete and decodes flag bits.
// ----------------------------------------------------------------------------
module crcfr_back import crcfr_pkg::*; (
	input  rec_t               head,
	input  cfg_t               cfg,
	output logic [7:0]         data_byte,
	output logic [1:0]         byte_kind,
	output logic [FLAGS_W-1:0] frame_flags,
	output logic [LEN_W-1:0]   payload_length,
	output logic               compressed,
	output logic               mac_present,
	output logic               frame_done,
	output logic [1:0]         status
);

	logic [FLAGS_W-1:0] fl;

	assign fl             = head.flags_ok ? head.flags : '0;
	assign data_byte      = head.data;
	assign byte_kind      = head.kind;
	assign frame_flags    = fl;
	assign payload_length = head.len_ok ? head.length : '0;
	assign compressed     = |(fl & cfg.comp_mask);
	assign mac_present    = |(fl & cfg.mac_mask);
	assign frame_done     = head.done;
	assign status         = head.status;

endmodule

[hw/rtl/crc_frame_receiver.sv]
// ----------------------------------------------------------------------------
// crc_frame_receiver
// Byte-serial deframer for length-prefixed frames with CRC-32 payload check.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: rx_byte is taken on a clock edge with
//   push high and full low. Output side is a queue read port: while empty is
//   low the oldest result item sits on data_byte..status, and pop with empty
//   low takes it. Every input byte yields exactly one result item.
//   An item pushed on a clock edge is visible at the outputs in the following
//   cycle, with empty low. Throughput: one item per cycle while full is low,
//   sustained; the parser's state update (header counter plus the unrolled
//   CRC-32 byte step) is combinational and registered on each accepted byte.
//   A 4-entry item queue sits between the parser and the outputs; when the
//   receiver stops popping, up to 4 items collect, then full rises and the
//   input side stalls. Nothing is dropped.
//   Reset (arst_n low) empties the queue, returns the parser to the first
//   header byte and loads the register defaults (max_payload_bytes = 2^20,
//   all others 0). There is no clearing pass.
//   Registers are written through cfg_wr_en/cfg_index/cfg_data. The user must
//   write them only while no items are in flight; the block leaves this to them.
// ----------------------------------------------------------------------------
module crc_frame_receiver import crcfr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// input side
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           rx_byte,
	// output side
	output logic                 empty,
	input  logic                 pop,
	output logic [7:0]           data_byte,
	output logic [1:0]           byte_kind,
	output logic [FLAGS_W-1:0]   frame_flags,
	output logic [LEN_W-1:0]     payload_length,
	output logic                 compressed,
	output logic                 mac_present,
	output logic                 frame_done,
	output logic [1:0]           status
);

	cfg_t cfg_q;
	rec_t front_rec;
	rec_t head_rec;
	logic fire;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic       <= '0;
			cfg_q.mac_mask    <= '0;
			cfg_q.comp_mask   <= '0;
			cfg_q.max_payload <= MAX_PAYLOAD_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MAGIC:       cfg_q.magic       <= cfg_data[MAGIC_W-1:0];
				REG_MAC_MASK:    cfg_q.mac_mask    <= cfg_data[FLAGS_W-1:0];
				REG_COMP_MASK:   cfg_q.comp_mask   <= cfg_data[FLAGS_W-1:0];
				REG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// parser advances only on an accepted byte
	assign fire = push & ~full;

	crcfr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.rx_byte (rx_byte),
		.cfg     (cfg_q),
		.rec     (front_rec)
	);

	crcfr_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.din    (front_rec),
		.rd_en  (pop),
		.full   (full),
		.empty  (empty),
		.dout   (head_rec)
	);

	crcfr_back u_back (
		.head           (head_rec),
		.cfg            (cfg_q),
		.data_byte      (data_byte),
		.byte_kind      (byte_kind),
		.frame_flags    (frame_flags),
		.payload_length (payload_length),
		.compressed     (compressed),
		.mac_present    (mac_present),
		.frame_done     (frame_done),
		.status         (status)
	);

endmodule

[hw/rtl/crcfr_checker.sv]
// ----------------------------------------------------------------------------
// crcfr_checker
// Port-level checks on the frame receiver's result stream.
// ----------------------------------------------------------------------------
module crcfr_checker import crcfr_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic [7:0]         data_byte,
	input logic [1:0]         byte_kind,
	input logic [FLAGS_W-1:0] frame_flags,
	input logic [LEN_W-1:0]   payload_length,
	input logic               frame_done,
	input logic [1:0]         status
);

	// an error status always ends the frame
	a_err_ends: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status != ST_OK |-> frame_done)
		else $error("error status without frame end");

	// target name bytes never end a frame
	a_target_no_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && byte_kind == KIND_TARGET |-> !frame_done)
		else $error("frame ended on a target name byte");

	// payload bytes only exist with a nonzero length
	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && byte_kind == KIND_PAYLOAD |-> payload_length != '0)
		else $error("payload byte with zero length");

	// bad magic is seen before the flags are complete
	a_magic_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status == ST_BAD_MAGIC |-> byte_kind == KIND_HEADER && frame_flags == '0)
		else $error("bad magic reported outside the magic field");

	// a waiting item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(data_byte) && $stable(byte_kind))
		else $error("waiting item changed");

endmodule

bind crc_frame_receiver crcfr_checker u_crcfr_checker (.*);
